>>> rtl/core/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI command exchange package
// Shared transaction types, sequencer state and command constants.
// ----------------------------------------------------------------------------
package sdspi_pkg;

   localparam logic [7:0] ACMD_FLAG   = 8'h80;
   localparam logic [7:0] CMD_MASK    = 8'h7F;
   localparam logic [7:0] IDLE_BYTE   = 8'hFF;
   localparam logic [7:0] CMD_APP     = 8'h77;
   localparam logic [7:0] CMD_STATUS  = 8'h4D;
   localparam logic [7:0] CMD_IF_COND = 8'h48;
   localparam logic [7:0] CMD_OCR     = 8'h7A;
   localparam logic [7:0] WAIT_LIMIT_RESET = 8'd8;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_BYTE  = 1'b1;

   localparam logic [2:0] FRAME_LAST_INDEX = 3'd5;
   localparam logic [2:0] STATUS_SKIP      = 3'd2;
   localparam logic [2:0] COLLECT_BYTES    = 3'd4;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_SEND    = 4'd1,
      PH_POLL    = 4'd2,
      PH_STAT    = 4'd3,
      PH_COLLECT = 4'd4,
      PH_TRAIL   = 4'd5,
      PH_DESEL   = 4'd6
   } phase_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  command;
      logic [31:0] argument;
      logic [7:0]  check_byte;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic        send_valid;
      logic [7:0]  send_byte;
      logic        chip_select;
      logic        done_res;
      logic        timed_out;
      logic        prefix_rejected;
      logic [31:0] response;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  byte_counter;
      logic [7:0]  poll_counter;
      logic [7:0]  latched_command;
      logic [31:0] latched_argument;
      logic [7:0]  latched_check;
      logic        prefix_pending;
      logic [31:0] collected_response;
      logic        timeout_seen;
   } ctx_type;

   localparam ctx_type CTX_RESET = '{
      phase:              PH_IDLE,
      byte_counter:       3'd0,
      poll_counter:       8'd0,
      latched_command:    8'd0,
      latched_argument:   32'd0,
      latched_check:      8'd0,
      prefix_pending:     1'b0,
      collected_response: 32'd0,
      timeout_seen:       1'b0
   };

endpackage

>>> rtl/core/sdspi_step.sv
// ----------------------------------------------------------------------------
// SD SPI command sequencer step
// Computes the next sequencer state and the result of one transaction.
// ----------------------------------------------------------------------------
module sdspi_step (
   input  sdspi_pkg::ctx_type cur,
   input  sdspi_pkg::req_type item,
   input  logic [7:0]         wait_limit,
   output sdspi_pkg::ctx_type nxt,
   output sdspi_pkg::rsp_type rsp
);
   import sdspi_pkg::*;

   function automatic logic [7:0] current_cmd(input ctx_type c);
      current_cmd = c.prefix_pending ? CMD_APP : (c.latched_command & CMD_MASK);
   endfunction

   function automatic logic [7:0] frame_byte(input ctx_type c, input logic [2:0] k);
      logic [31:0] arg;
      logic [7:0]  chk;
      arg = c.prefix_pending ? 32'd0 : c.latched_argument;
      chk = c.prefix_pending ? IDLE_BYTE : c.latched_check;
      case (k)
         3'd0:    frame_byte = current_cmd(c);
         3'd1:    frame_byte = arg[31:24];
         3'd2:    frame_byte = arg[23:16];
         3'd3:    frame_byte = arg[15:8];
         3'd4:    frame_byte = arg[7:0];
         default: frame_byte = chk;
      endcase
   endfunction

   logic [7:0] limit;
   logic [7:0] cmd;
   logic [2:0] count_next;
   logic       start_frame;

   assign limit = (wait_limit == 8'd0) ? 8'd1 : wait_limit;
   assign cmd   = current_cmd(cur);

   always_comb begin
      nxt         = cur;
      start_frame = 1'b0;
      count_next  = cur.byte_counter + 3'd1;
      rsp.send_valid      = 1'b1;
      rsp.send_byte       = IDLE_BYTE;
      rsp.chip_select     = 1'b0;
      rsp.done_res        = 1'b0;
      rsp.timed_out       = 1'b0;
      rsp.prefix_rejected = 1'b0;
      rsp.response        = 32'd0;

      if (item.mode == MODE_START) begin
         nxt.latched_command  = item.command;
         nxt.latched_argument = item.argument;
         nxt.latched_check    = item.check_byte;
         nxt.prefix_pending   = |(item.command & ACMD_FLAG);
         start_frame          = 1'b1;
      end else begin
         case (cur.phase)
            PH_SEND: begin
               if (cur.byte_counter < FRAME_LAST_INDEX) begin
                  nxt.byte_counter = count_next;
                  rsp.send_byte    = frame_byte(cur, count_next);
               end else if (cmd == CMD_STATUS) begin
                  nxt.phase        = PH_STAT;
                  nxt.byte_counter = 3'd0;
               end else begin
                  nxt.phase        = PH_POLL;
                  nxt.poll_counter = 8'd1;
               end
            end
            PH_POLL: begin
               if (item.rx_byte != IDLE_BYTE) begin
                  nxt.collected_response = {24'd0, item.rx_byte};
                  if (cmd inside {CMD_IF_COND, CMD_OCR}) begin
                     nxt.phase        = PH_COLLECT;
                     nxt.byte_counter = 3'd0;
                  end else begin
                     nxt.phase = PH_TRAIL;
                  end
               end else if (cur.poll_counter >= limit) begin
                  nxt.timeout_seen = 1'b1;
                  nxt.phase        = PH_TRAIL;
               end else begin
                  nxt.poll_counter = cur.poll_counter + 8'd1;
               end
            end
            PH_STAT: begin
               if (cur.byte_counter < STATUS_SKIP) begin
                  nxt.byte_counter = count_next;
               end else begin
                  nxt.collected_response = {24'd0, item.rx_byte};
                  nxt.timeout_seen       = (item.rx_byte == IDLE_BYTE);
                  nxt.phase              = PH_TRAIL;
               end
            end
            PH_COLLECT: begin
               nxt.collected_response = {cur.collected_response[23:0], item.rx_byte};
               nxt.byte_counter       = count_next;
               if (count_next >= COLLECT_BYTES) begin
                  nxt.phase = PH_TRAIL;
               end
            end
            PH_TRAIL: begin
               if (cur.timeout_seen) begin
                  nxt.phase       = PH_DESEL;
                  rsp.chip_select = 1'b1;
               end else if (cur.prefix_pending) begin
                  nxt.prefix_pending = 1'b0;
                  if (cur.collected_response > 32'd1) begin
                     nxt.phase           = PH_IDLE;
                     rsp.send_valid      = 1'b0;
                     rsp.send_byte       = 8'd0;
                     rsp.done_res        = 1'b1;
                     rsp.prefix_rejected = 1'b1;
                     rsp.response        = cur.collected_response;
                  end else begin
                     start_frame = 1'b1;
                  end
               end else begin
                  nxt.phase      = PH_IDLE;
                  rsp.send_valid = 1'b0;
                  rsp.send_byte  = 8'd0;
                  rsp.done_res   = 1'b1;
                  rsp.response   = cur.collected_response;
               end
            end
            PH_DESEL: begin
               if (cur.prefix_pending) begin
                  nxt.prefix_pending = 1'b0;
                  start_frame        = 1'b1;
               end else begin
                  nxt.phase       = PH_IDLE;
                  rsp.send_valid  = 1'b0;
                  rsp.send_byte   = 8'd0;
                  rsp.chip_select = 1'b1;
                  rsp.done_res    = 1'b1;
                  rsp.timed_out   = 1'b1;
               end
            end
            default: begin
               nxt.phase       = PH_IDLE;
               rsp.send_valid  = 1'b0;
               rsp.send_byte   = 8'd0;
               rsp.chip_select = cur.timeout_seen;
            end
         endcase
      end

      if (start_frame) begin
         nxt.phase              = PH_SEND;
         nxt.byte_counter       = 3'd0;
         nxt.poll_counter       = 8'd0;
         nxt.collected_response = 32'd0;
         nxt.timeout_seen       = 1'b0;
         rsp.send_valid         = 1'b1;
         rsp.send_byte          = frame_byte(nxt, 3'd0);
         rsp.chip_select        = 1'b0;
         rsp.done_res           = 1'b0;
         rsp.timed_out          = 1'b0;
         rsp.prefix_rejected    = 1'b0;
         rsp.response           = 32'd0;
      end
   end

endmodule

>>> rtl/core/sd_spi_command_exchange.sv
// ----------------------------------------------------------------------------
// SD SPI command exchange
// Host-side SD card SPI-mode command sequencer that drives a byte exchanger.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   sdspi_pkg::req_type
//   rsp      out        rsp_valid/rsp_ready   sdspi_pkg::rsp_type
//   csr      in         csr_wr_en             8-bit response wait limit
//
// The input register captures a transaction at its accepting edge, and the
// sequencer step loads its result into the result register once that is empty or taken.
// One transaction is accepted every cycle while results are taken.
// A stalled result holds the result register, and the input register then
// fills and lowers req_ready. Reset is synchronous and returns the sequencer
// to idle with the wait limit at eight.
// ----------------------------------------------------------------------------
module sd_spi_command_exchange (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sdspi_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sdspi_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data
);
   import sdspi_pkg::*;

   logic       in_valid_ff;
   logic       in_valid_in;
   req_type    in_data_ff;
   logic       out_valid_ff;
   logic       out_valid_in;
   rsp_type    out_data_ff;
   rsp_type    out_data_in;
   ctx_type    state_ff;
   ctx_type    state_in;
   logic [7:0] limit_ff;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   sdspi_step u_step (
      .cur        (state_ff),
      .item       (in_data_ff),
      .wait_limit (limit_ff),
      .nxt        (state_in),
      .rsp        (out_data_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= CTX_RESET;
         limit_ff     <= WAIT_LIMIT_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   a_idle_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.send_valid |-> rsp_data.send_byte == 8'd0)
      else $error("send_byte nonzero without an exchange");

   a_timeout_deselects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.timed_out |->
         rsp_data.done_res && rsp_data.chip_select && rsp_data.response == 32'd0)
      else $error("timeout result without deselect or with response");

   a_done_no_exchange: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> !rsp_data.send_valid)
      else $error("completion also requests an exchange");

   a_reject_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.prefix_rejected |->
         rsp_data.done_res && !rsp_data.timed_out && rsp_data.response > 32'd1)
      else $error("prefix rejection with inconsistent flags");

   a_step_follows_entry: assert property (@(posedge clock) disable iff (reset)
      advance && !(out_valid_ff && !rsp_ready) |=> rsp_valid)
      else $error("accepted transaction produced no result");

endmodule
